FILE: rtl/core/rcesc_pkg.sv
// Shared types and constants for the carry-less range coder with escape symbols.
// Depends on nothing; the top level refers to it by scoped names.
`default_nettype none

package rcesc_pkg;

   // Operation codes carried on the request channel.
   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_ENCODE = 2'd1;
   localparam logic [1:0] OP_FLUSH  = 2'd2;

   // Status codes on the response channel.
   localparam logic [1:0] STAT_BYTE      = 2'd0;
   localparam logic [1:0] STAT_ZERO_FREQ = 2'd1;

   // Field widths fixed by the interface.
   localparam int SYM_W  = 13;
   localparam int ADDR_W = 8;

   // Escape handling.
   localparam logic [1:0] ESC_NONE  = 2'd0;
   localparam logic [1:0] ESC_SHORT = 2'd1;
   localparam logic [1:0] ESC_LONG  = 2'd2;

   localparam logic [ADDR_W-1:0] SYM_ESC_SHORT   = 8'hFE;
   localparam logic [ADDR_W-1:0] SYM_ESC_LONG    = 8'hFF;
   localparam logic [SYM_W-1:0]  SHORT_START     = 13'h0FE;
   localparam logic [SYM_W-1:0]  LONG_START      = 13'h1FE;
   localparam int                SHORT_EXTRA_W   = 8;
   localparam int                LONG_EXTRA_W    = 13;

   // Coder state at reset and after a flush.
   localparam logic [31:0] RANGE_RESET = 32'hFFFF_FFFF;
   localparam logic [31:0] LOW_RESET   = 32'h0000_0000;

   // One response word without its last flag.
   typedef struct packed {
      logic [1:0] status;
      logic [7:0] data;
   } rsp_word_type;

endpackage

`default_nettype wire

FILE: rtl/core/range_coder_with_escape_symbols_top.sv
// Top level of the carry-less range coder with escape symbols: sequencer, shared
// multiplier, frequency table memory and response register. Uses rcesc_pkg.
`default_nettype none

// How to use this block.
// Request words arrive on req_* with a valid/stall handshake; a word is taken at
// a rising edge with req_valid high and req_stall low. A load word writes one
// entry of the frequency and cumulative table and is finished in that cycle. An
// encode word codes its symbol, sending an escape and an extra field for large
// symbols, and produces zero or more response words; a flush word produces the
// four bytes of the low bound and restarts the coder. Every response word leaves
// on rsp_* and the final one caused by a request carries rsp_last_of_run.
// Each request is worked through by a small sequencer around a single shared
// 32 by max(FREQ_BITS, 13) multiplier, one request at a time, and req_stall
// stays high until it is finished. An encode word runs a chain of dependent
// multiplies through the shared multiplier and then a byte-by-byte
// renormalisation loop, a second time for the extra field when an escape is
// sent; a flush sends its four bytes in turn, and a load or a no-op is done
// when it is taken. One byte is held back in a pending register so that the
// last flag is known before it is sent; while the receiver stalls, the
// sequencer waits once both this register and the response register are full.
// Synchronous reset returns the coder to its initial low bound and range; the
// table contents are undefined until loaded.

module range_coder_with_escape_symbols_top #(
   parameter int FREQ_BITS = 14
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  wire [1:0]            req_opcode,
   input  wire [12:0]           req_symbol,
   input  wire [FREQ_BITS-1:0]  req_frequency,
   input  wire [FREQ_BITS-1:0]  req_cumulative,
   output logic                 rsp_valid,
   input  wire                  rsp_stall,
   output logic [1:0]           rsp_status,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_last_of_run
);

   localparam int DEPTH   = 1 << rcesc_pkg::ADDR_W;
   localparam int ENTRY_W = 2 * FREQ_BITS;
   localparam int MUL_B_W = (FREQ_BITS > rcesc_pkg::SYM_W) ? FREQ_BITS : rcesc_pkg::SYM_W;
   localparam int MUL_W   = 32 + MUL_B_W;

   // Sequencer states.
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_READ  = 4'd1;
   localparam logic [3:0] ST_MUL1  = 4'd2;
   localparam logic [3:0] ST_ADD1  = 4'd3;
   localparam logic [3:0] ST_MUL2  = 4'd4;
   localparam logic [3:0] ST_SET2  = 4'd5;
   localparam logic [3:0] ST_RN1   = 4'd6;
   localparam logic [3:0] ST_RN2   = 4'd7;
   localparam logic [3:0] ST_EXT   = 4'd8;
   localparam logic [3:0] ST_MUL3  = 4'd9;
   localparam logic [3:0] ST_ADD3  = 4'd10;
   localparam logic [3:0] ST_FLUSH = 4'd11;
   localparam logic [3:0] ST_FIN   = 4'd12;

   // Table memory: frequency in the upper half, cumulative start in the lower.
   logic [ENTRY_W-1:0] table_mem [DEPTH];
   logic [ENTRY_W-1:0] rd_ff;

   logic [3:0]  state_ff, state_in;
   logic [31:0] low_ff, low_in;
   logic [31:0] rng_ff, rng_in;
   logic [31:0] prod_ff, prod_in;
   logic [12:0] extra_ff, extra_in;
   logic [1:0]  esc_ff, esc_in;
   logic        phase_ff, phase_in;
   logic [2:0]  k_ff, k_in;
   logic        flush_ff, flush_in;
   logic        pend_valid_ff, pend_valid_in;
   rcesc_pkg::rsp_word_type pend_ff, pend_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rcesc_pkg::rsp_word_type rsp_word_ff;
   logic        rsp_last_ff;

   logic                      accept_c;
   logic                      mem_we_c, mem_re_c;
   logic [rcesc_pkg::ADDR_W-1:0] rd_addr_c;
   logic [FREQ_BITS-1:0]      freq_c, cum_c;
   logic [MUL_B_W-1:0]        mul_b_c;
   logic [MUL_W-1:0]          mul_full_c;
   logic [31:0]               sum_c, neg_low_c;
   logic                      out_free_c, can_go_c, push_c, push_last_c;

   assign req_stall  = (state_ff != ST_IDLE);
   assign accept_c   = req_valid && !req_stall;
   assign freq_c     = rd_ff[ENTRY_W-1:FREQ_BITS];
   assign cum_c      = rd_ff[FREQ_BITS-1:0];
   assign sum_c      = low_ff + rng_ff;
   assign neg_low_c  = 32'd0 - low_ff;
   assign out_free_c = !rsp_valid_ff || !rsp_stall;
   assign can_go_c   = !pend_valid_ff || out_free_c;

   // The one multiplier of the block; the product is truncated to 32 bits.
   assign mul_full_c = MUL_W'(rng_ff) * MUL_W'(mul_b_c);

   // Table writes and the registered read for an encode word.
   assign mem_we_c = accept_c && (req_opcode == rcesc_pkg::OP_LOAD)
                     && (req_symbol[12:rcesc_pkg::ADDR_W] == '0);
   assign mem_re_c = accept_c && (req_opcode == rcesc_pkg::OP_ENCODE);

   always_comb begin
      if (req_symbol < rcesc_pkg::SHORT_START) begin
         rd_addr_c = req_symbol[rcesc_pkg::ADDR_W-1:0];
      end else if (req_symbol < rcesc_pkg::LONG_START) begin
         rd_addr_c = rcesc_pkg::SYM_ESC_SHORT;
      end else begin
         rd_addr_c = rcesc_pkg::SYM_ESC_LONG;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we_c) begin
         table_mem[req_symbol[rcesc_pkg::ADDR_W-1:0]] <= {req_frequency, req_cumulative};
      end
      if (mem_re_c) begin
         rd_ff <= table_mem[rd_addr_c];
      end
   end

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      low_in        = low_ff;
      rng_in        = rng_ff;
      prod_in       = prod_ff;
      extra_in      = extra_ff;
      esc_in        = esc_ff;
      phase_in      = phase_ff;
      k_in          = k_ff;
      flush_in      = flush_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      mul_b_c       = '0;
      push_c        = 1'b0;
      push_last_c   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept_c) begin
               if (req_opcode == rcesc_pkg::OP_ENCODE) begin
                  flush_in = 1'b0;
                  state_in = ST_READ;
                  if (req_symbol < rcesc_pkg::SHORT_START) begin
                     esc_in   = rcesc_pkg::ESC_NONE;
                     extra_in = '0;
                  end else if (req_symbol < rcesc_pkg::LONG_START) begin
                     esc_in   = rcesc_pkg::ESC_SHORT;
                     extra_in = req_symbol - rcesc_pkg::SHORT_START;
                  end else begin
                     esc_in   = rcesc_pkg::ESC_LONG;
                     extra_in = req_symbol;
                  end
               end else if (req_opcode == rcesc_pkg::OP_FLUSH) begin
                  flush_in = 1'b1;
                  k_in     = '0;
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_READ: begin
            if (freq_c == '0) begin
               // A symbol with no probability cannot be coded; report it and
               // leave the coder untouched.
               pend_in       = '{status: rcesc_pkg::STAT_ZERO_FREQ, data: 8'd0};
               pend_valid_in = 1'b1;
               state_in      = ST_FIN;
            end else begin
               rng_in   = rng_ff >> FREQ_BITS;
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            mul_b_c  = MUL_B_W'(cum_c);
            prod_in  = mul_full_c[31:0];
            state_in = ST_ADD1;
         end
         ST_ADD1: begin
            low_in   = low_ff + prod_ff;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            mul_b_c  = MUL_B_W'(freq_c);
            prod_in  = mul_full_c[31:0];
            state_in = ST_SET2;
         end
         ST_SET2: begin
            rng_in   = prod_ff;
            k_in     = '0;
            phase_in = 1'b0;
            state_in = ST_RN1;
         end
         ST_RN1: begin
            // Top byte settled: shift it out.
            if (!k_ff[2] && (low_ff[31:24] == sum_c[31:24])) begin
               if (can_go_c) begin
                  push_c        = pend_valid_ff;
                  pend_in       = '{status: rcesc_pkg::STAT_BYTE, data: low_ff[31:24]};
                  pend_valid_in = 1'b1;
                  rng_in        = rng_ff << 8;
                  low_in        = low_ff << 8;
                  k_in          = k_ff + 3'd1;
               end
            end else begin
               k_in     = '0;
               state_in = ST_RN2;
            end
         end
         ST_RN2: begin
            // Range underflow: force a byte out and rebuild the range.
            if (!k_ff[2] && (rng_ff[31:16] == '0)) begin
               if (can_go_c) begin
                  push_c        = pend_valid_ff;
                  pend_in       = '{status: rcesc_pkg::STAT_BYTE, data: low_ff[31:24]};
                  pend_valid_in = 1'b1;
                  rng_in        = {8'd0, neg_low_c[15:0], 8'd0};
                  low_in        = low_ff << 8;
                  k_in          = k_ff + 3'd1;
               end
            end else if (!phase_ff && (esc_ff != rcesc_pkg::ESC_NONE)) begin
               state_in = ST_EXT;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_EXT: begin
            if (esc_ff == rcesc_pkg::ESC_SHORT) begin
               rng_in = rng_ff >> rcesc_pkg::SHORT_EXTRA_W;
            end else begin
               rng_in = rng_ff >> rcesc_pkg::LONG_EXTRA_W;
            end
            state_in = ST_MUL3;
         end
         ST_MUL3: begin
            mul_b_c  = MUL_B_W'(extra_ff);
            prod_in  = mul_full_c[31:0];
            state_in = ST_ADD3;
         end
         ST_ADD3: begin
            low_in   = low_ff + prod_ff;
            phase_in = 1'b1;
            k_in     = '0;
            state_in = ST_RN1;
         end
         ST_FLUSH: begin
            if (can_go_c) begin
               push_c        = pend_valid_ff;
               pend_in       = '{status: rcesc_pkg::STAT_BYTE, data: low_ff[31:24]};
               pend_valid_in = 1'b1;
               low_in        = low_ff << 8;
               k_in          = k_ff + 3'd1;
               if (k_ff == 3'd3) begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_FIN: begin
            if (!pend_valid_ff || out_free_c) begin
               push_c        = pend_valid_ff;
               push_last_c   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
               if (flush_ff) begin
                  low_in = rcesc_pkg::LOW_RESET;
                  rng_in = rcesc_pkg::RANGE_RESET;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (push_c) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         low_ff        <= rcesc_pkg::LOW_RESET;
         rng_ff        <= rcesc_pkg::RANGE_RESET;
         k_ff          <= '0;
         phase_ff      <= 1'b0;
         flush_ff      <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         low_ff        <= low_in;
         rng_ff        <= rng_in;
         k_ff          <= k_in;
         phase_ff      <= phase_in;
         flush_ff      <= flush_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      extra_ff <= extra_in;
      esc_ff   <= esc_in;
      pend_ff  <= pend_in;
      if (push_c) begin
         rsp_word_ff <= pend_ff;
         rsp_last_ff <= push_last_c;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_word_ff.status;
   assign rsp_out_byte    = rsp_word_ff.data;
   assign rsp_last_of_run = rsp_last_ff;

   // The pending byte is always handed on before the sequencer goes idle.
   a_idle_no_pending : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff)
      else $error("pending byte left behind in idle");

   // A word is moved into the response register only when that register is free.
   a_push_when_free : assert property (@(posedge clock) disable iff (reset)
      push_c |-> (!rsp_valid_ff || !rsp_stall))
      else $error("response word overwritten while stalled");

   // The renormalisation and flush byte counters never pass four.
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      k_ff <= 3'd4)
      else $error("byte counter out of range");

   // An accepted encode word starts with the table read.
   a_encode_start : assert property (@(posedge clock) disable iff (reset)
      (accept_c && (req_opcode == rcesc_pkg::OP_ENCODE)) |=> (state_ff == ST_READ))
      else $error("encode word did not start the sequence");

endmodule

`default_nettype wire

FILE: tb/sv/tb_range_coder_with_escape_symbols_top.sv
// Self-checking testbench for the range coder with escape symbols: directed table, then random
// table loads, symbol runs and flushes, checked word by word against a coder model or the table.
// Depends on rcesc_pkg and range_coder_with_escape_symbols_top; needs no files or arguments.
`default_nettype none

module tb_range_coder_with_escape_symbols_top;

   localparam int          FREQ_W        = 14;
   localparam logic [1:0]  OP_NOP        = 2'd3;
   localparam logic [12:0] SYM_MAX       = 13'h1FFF;
   localparam int          RENORM_CAP    = 4;
   localparam int          TOTAL_WORDS   = 430;
   localparam int          DRAIN_CYCLES  = 40;
   localparam int          LONG_HOLD     = 300;

   // One response word as the receiver sees it.
   typedef struct packed {
      logic [1:0] status;
      logic [7:0] data;
      logic       last;
   } coded_word_type;

   // One row of the directed table. Where typed is set, the row says outright what comes
   // back: count words of the given status and byte, the last one flagged.
   typedef struct {
      logic [1:0]  op;
      logic [12:0] sym;
      logic [13:0] frq;
      logic [13:0] cml;
      bit          typed;
      int          count;
      logic [1:0]  status;
      logic [7:0]  data;
   } stim_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [1:0]          req_opcode = OP_NOP;
   logic [12:0]         req_symbol = '0;
   logic [FREQ_W-1:0]   req_frequency = '0;
   logic [FREQ_W-1:0]   req_cumulative = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [1:0]          rsp_status;
   logic [7:0]          rsp_out_byte;
   logic                rsp_last_of_run;

   range_coder_with_escape_symbols_top #(
      .FREQ_BITS(FREQ_W)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_symbol      (req_symbol),
      .req_frequency   (req_frequency),
      .req_cumulative  (req_cumulative),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 0;
   end

   // ---------------------------------------------------------------------------------------
   // Coder model. It keeps its own copy of the tables and of the low bound and range, and
   // for each accepted request word it leaves the words that must come back in item_words.
   // ---------------------------------------------------------------------------------------
   logic [13:0]     freq_tab [256];
   logic [13:0]     cum_tab  [256];
   logic [31:0]     coder_low   = rcesc_pkg::LOW_RESET;
   logic [31:0]     coder_range = rcesc_pkg::RANGE_RESET;
   coded_word_type  item_words [$];
   coded_word_type  coded_bytes_q [$];

   initial begin
      foreach (freq_tab[i]) begin
         freq_tab[i] = '0;
         cum_tab[i]  = '0;
      end
   end

   // Renormalisation: first shift out bytes whose top bits can no longer change, then, if
   // the range has become too small, give up the straddling bytes and clamp the range. Each
   // of the two loops stops after four bytes.
   task automatic renorm_bytes();
      logic [31:0] top;
      logic [31:0] negated;
      int          k;
      k   = 0;
      top = coder_low + coder_range;
      while (k < RENORM_CAP && (coder_low ^ top) <= 32'h00FF_FFFF) begin
         item_words.push_back(coded_word_type'{rcesc_pkg::STAT_BYTE, coder_low[31:24], 1'b0});
         coder_range = coder_range << 8;
         coder_low   = coder_low << 8;
         top         = coder_low + coder_range;
         k++;
      end
      k = 0;
      while (k < RENORM_CAP && coder_range <= 32'h0000_FFFF) begin
         item_words.push_back(coded_word_type'{rcesc_pkg::STAT_BYTE, coder_low[31:24], 1'b0});
         negated     = 32'd0 - coder_low;
         coder_range = {8'd0, negated[15:0], 8'd0};
         coder_low   = coder_low << 8;
         k++;
      end
   endtask

   task automatic predict_word(input logic [1:0] op, input logic [12:0] sym,
                               input logic [13:0] frq, input logic [13:0] cml);
      logic [7:0]  base;
      logic [31:0] extra;
      int          shift;
      item_words = {};
      case (op)
         rcesc_pkg::OP_LOAD: begin
            // Indexes beyond the table are dropped without a word.
            if (sym < 256) begin
               freq_tab[sym[7:0]] = frq;
               cum_tab[sym[7:0]]  = cml;
            end
         end
         rcesc_pkg::OP_FLUSH: begin
            item_words.push_back(coded_word_type'{rcesc_pkg::STAT_BYTE, coder_low[31:24], 1'b0});
            item_words.push_back(coded_word_type'{rcesc_pkg::STAT_BYTE, coder_low[23:16], 1'b0});
            item_words.push_back(coded_word_type'{rcesc_pkg::STAT_BYTE, coder_low[15:8], 1'b0});
            item_words.push_back(coded_word_type'{rcesc_pkg::STAT_BYTE, coder_low[7:0], 1'b0});
            coder_low   = rcesc_pkg::LOW_RESET;
            coder_range = rcesc_pkg::RANGE_RESET;
         end
         rcesc_pkg::OP_ENCODE: begin
            if (sym < rcesc_pkg::SHORT_START) begin
               base  = sym[7:0];
               extra = 0;
               shift = 0;
            end else if (sym < rcesc_pkg::LONG_START) begin
               base  = rcesc_pkg::SYM_ESC_SHORT;
               extra = 32'(sym - rcesc_pkg::SHORT_START);
               shift = rcesc_pkg::SHORT_EXTRA_W;
            end else begin
               base  = rcesc_pkg::SYM_ESC_LONG;
               extra = 32'(sym);
               shift = rcesc_pkg::LONG_EXTRA_W;
            end
            if (freq_tab[base] == 0) begin
               // A zero frequency base is refused and leaves the coder untouched.
               item_words.push_back(coded_word_type'{rcesc_pkg::STAT_ZERO_FREQ, 8'h00, 1'b0});
            end else begin
               coder_range = coder_range >> FREQ_W;
               coder_low   = coder_low + cum_tab[base] * coder_range;
               coder_range = coder_range * freq_tab[base];
               renorm_bytes();
               if (shift != 0) begin
                  coder_range = coder_range >> shift;
                  coder_low   = coder_low + extra * coder_range;
                  renorm_bytes();
               end
            end
         end
         default: ;
      endcase
      if (item_words.size() > 0) item_words[item_words.size()-1].last = 1'b1;
   endtask

   // ---------------------------------------------------------------------------------------
   // Checking. Responses and requests are both looked at in one process on the rising edge,
   // the response first, so the order of processes within a time step cannot matter.
   // ---------------------------------------------------------------------------------------
   int          fail_count = 0;
   bit          typed_word = 1'b0;
   int          typed_count = 0;
   logic [1:0]  typed_status = rcesc_pkg::STAT_BYTE;
   logic [7:0]  typed_byte = 8'h00;

   task automatic report_mismatch(input string what);
      fail_count++;
      $display("ERROR at %0t: %s", $time, what);
   endtask

   always @(posedge clock) begin : check_words
      coded_word_type got;
      coded_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = coded_word_type'{rsp_status, rsp_out_byte, rsp_last_of_run};
         if (coded_bytes_q.size() == 0) begin
            report_mismatch($sformatf("word with nothing expected: status %0d byte %02h last %0b",
                                      got.status, got.data, got.last));
         end else begin
            want = coded_bytes_q.pop_front();
            if (got.status !== want.status || got.data !== want.data
                || got.last !== want.last)
               report_mismatch($sformatf(
                  "status %0d byte %02h last %0b, expected status %0d byte %02h last %0b",
                  got.status, got.data, got.last, want.status, want.data, want.last));
         end
      end
      if (!reset && req_valid && !req_stall) begin
         // The model always runs so that its state follows the block; a typed row then
         // replaces its words with the ones written in the table.
         predict_word(req_opcode, req_symbol, req_frequency, req_cumulative);
         if (typed_word) begin
            for (int j = 0; j < typed_count; j++)
               coded_bytes_q.push_back(coded_word_type'{typed_status, typed_byte,
                                                        j == typed_count - 1});
         end else begin
            foreach (item_words[j]) coded_bytes_q.push_back(item_words[j]);
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Receiver. It stalls on stretches of its own with a random stall rate, some of them with
   // no stalls at all. When asked, it holds off for a long count of cycles so that the block
   // backs up and stalls its request side.
   // ---------------------------------------------------------------------------------------
   bit hold_pending = 1'b0;

   initial begin : receiver
      int hold_left;
      int mode_left;
      int stall_pct;
      hold_left = 0;
      mode_left = 0;
      stall_pct = 0;
      forever begin
         @(negedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            hold_left    = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               mode_left = $urandom_range(8, 60);
               case ($urandom_range(0, 4))
                  0, 1:    stall_pct = 0;
                  2:       stall_pct = 25;
                  3:       stall_pct = 50;
                  default: stall_pct = 85;
               endcase
            end
            mode_left--;
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Sender. Words go out in bursts of random length with random gaps between them; the
   // payload is changed at the falling edge and held until the word is taken.
   // ---------------------------------------------------------------------------------------
   bit         loaded [256];
   logic [7:0] loaded_list [$];
   int         burst_left = 0;
   bit         gaps_off = 1'b0;
   int         words_counted = 0;

   task automatic pace_sender();
      int gap;
      if (gaps_off) return;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         repeat (gap) begin
            @(negedge clock);
            req_valid  <= 1'b0;
            req_opcode <= 2'($urandom);
            req_symbol <= 13'($urandom);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
   endtask

   task automatic send_word(input logic [1:0] op, input logic [12:0] sym,
                            input logic [13:0] frq, input logic [13:0] cml,
                            input bit typed = 1'b0, input int t_count = 0,
                            input logic [1:0] t_status = rcesc_pkg::STAT_BYTE,
                            input logic [7:0] t_byte = 8'h00);
      if (op == rcesc_pkg::OP_LOAD && sym < 256 && !loaded[sym[7:0]]) begin
         loaded[sym[7:0]] = 1'b1;
         loaded_list.push_back(sym[7:0]);
      end
      // Every word offered counts, the ignored ones too.
      words_counted++;
      pace_sender();
      @(negedge clock);
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_symbol     <= sym;
      req_frequency  <= frq;
      req_cumulative <= cml;
      typed_word     <= typed;
      typed_count    <= t_count;
      typed_status   <= t_status;
      typed_byte     <= t_byte;
      do @(posedge clock); while (req_stall);
   endtask

   // Stop offering words until every expected word has come back, then let the block settle.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (coded_bytes_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // A symbol that codes through the given loaded base: the base itself below the escapes,
   // a short escape with an 8-bit extra, or a long escape with the raw 13-bit value.
   function automatic logic [12:0] symbol_for(input logic [7:0] base);
      case (base)
         rcesc_pkg::SYM_ESC_SHORT: return rcesc_pkg::SHORT_START + 13'($urandom_range(0, 255));
         rcesc_pkg::SYM_ESC_LONG: begin
            if ($urandom_range(0, 4) == 0)
               return ($urandom_range(0, 1) != 0) ? rcesc_pkg::LONG_START : SYM_MAX;
            return 13'($urandom_range(rcesc_pkg::LONG_START, SYM_MAX));
         end
         default: return {5'd0, base};
      endcase
   endfunction

   task automatic encode_random();
      logic [7:0] base;
      base = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
      send_word(rcesc_pkg::OP_ENCODE, symbol_for(base), 14'($urandom), 14'($urandom));
   endtask

   // Loads a handful of entries. A sound table splits the total of 2^14 among them, often
   // with small slices so that many bytes come out, and now and then a zero frequency; a
   // wild table takes any values the fields allow.
   task automatic load_random_table(input bit wild);
      logic [7:0] picks [$];
      logic [7:0] cand;
      bit         dup;
      int         n;
      int         left;
      int         hi;
      int         f;
      n = $urandom_range(2, 10);
      if ($urandom_range(0, 3) != 0) picks.push_back(rcesc_pkg::SYM_ESC_SHORT);
      if ($urandom_range(0, 3) != 0) picks.push_back(rcesc_pkg::SYM_ESC_LONG);
      while (picks.size() < n) begin
         cand = 8'($urandom_range(0, rcesc_pkg::SHORT_START - 1));
         dup  = 1'b0;
         foreach (picks[j]) if (picks[j] == cand) dup = 1'b1;
         if (!dup) picks.push_back(cand);
      end
      left = 1 << FREQ_W;
      foreach (picks[j]) begin
         if (wild) begin
            send_word(rcesc_pkg::OP_LOAD, {5'd0, picks[j]}, 14'($urandom), 14'($urandom));
         end else if ($urandom_range(0, 9) == 0) begin
            send_word(rcesc_pkg::OP_LOAD, {5'd0, picks[j]}, 14'd0,
                      14'((1 << FREQ_W) - left));
         end else begin
            hi = left - (picks.size() - 1 - j);
            if (j == picks.size() - 1)         f = left;
            else if ($urandom_range(0, 1) != 0) f = $urandom_range(1, hi);
            else                                f = $urandom_range(1, (hi < 48) ? hi : 48);
            if (f > (1 << FREQ_W) - 1) f = (1 << FREQ_W) - 1;
            send_word(rcesc_pkg::OP_LOAD, {5'd0, picks[j]}, 14'(f),
                      14'((1 << FREQ_W) - left));
            left -= f;
         end
      end
   endtask

   // Directed part. After reset, a flush gives four zero bytes; loads, no-ops and loads
   // beyond the table give nothing; a zero frequency base gives one error word. Then the
   // extreme frequencies and every escape boundary are coded and checked by the model.
   localparam int DIRECTED_ROWS = 25;
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{rcesc_pkg::OP_FLUSH,  13'd0,    14'd0,    14'd0,     1'b1, 4, rcesc_pkg::STAT_BYTE, 8'h00},
      '{rcesc_pkg::OP_FLUSH,  13'd0,    14'd0,    14'd0,     1'b1, 4, rcesc_pkg::STAT_BYTE, 8'h00},
      '{OP_NOP,               SYM_MAX,  14'h3FFF, 14'h3FFF,  1'b1, 0, rcesc_pkg::STAT_BYTE, 8'h00},
      '{rcesc_pkg::OP_LOAD,   SYM_MAX,  14'h3FFF, 14'h3FFF,  1'b1, 0, rcesc_pkg::STAT_BYTE, 8'h00},
      '{rcesc_pkg::OP_LOAD,   13'd256,  14'd0,    14'd0,     1'b1, 0, rcesc_pkg::STAT_BYTE, 8'h00},
      '{rcesc_pkg::OP_LOAD,   13'd0,    14'd0,    14'd0,     1'b1, 0, rcesc_pkg::STAT_BYTE, 8'h00},
      '{rcesc_pkg::OP_ENCODE, 13'd0,    14'd0,    14'd0,     1'b1, 1,
        rcesc_pkg::STAT_ZERO_FREQ, 8'h00},
      '{rcesc_pkg::OP_LOAD,   13'd1,    14'h3FFF, 14'd0,     1'b1, 0, rcesc_pkg::STAT_BYTE, 8'h00},
      '{rcesc_pkg::OP_LOAD,   13'd253,  14'd1,    14'h3FFF,  1'b1, 0, rcesc_pkg::STAT_BYTE, 8'h00},
      '{rcesc_pkg::OP_LOAD,   13'd254,  14'd4096, 14'd8192,  1'b1, 0, rcesc_pkg::STAT_BYTE, 8'h00},
      '{rcesc_pkg::OP_LOAD,   13'd255,  14'd4096, 14'd12288, 1'b1, 0, rcesc_pkg::STAT_BYTE, 8'h00},
      '{rcesc_pkg::OP_ENCODE, 13'd1,    14'd0,    14'd0,     1'b0, 0, rcesc_pkg::STAT_BYTE, 8'h00},
      '{rcesc_pkg::OP_ENCODE, 13'd253,  14'd0,    14'd0,     1'b0, 0, rcesc_pkg::STAT_BYTE, 8'h00},
      '{rcesc_pkg::OP_ENCODE, 13'd254,  14'd0,    14'd0,     1'b0, 0, rcesc_pkg::STAT_BYTE, 8'h00},
      '{rcesc_pkg::OP_ENCODE, 13'd509,  14'd0,    14'd0,     1'b0, 0, rcesc_pkg::STAT_BYTE, 8'h00},
      '{rcesc_pkg::OP_ENCODE, 13'd510,  14'd0,    14'd0,     1'b0, 0, rcesc_pkg::STAT_BYTE, 8'h00},
      '{rcesc_pkg::OP_ENCODE, SYM_MAX,  14'h3FFF, 14'h3FFF,  1'b0, 0, rcesc_pkg::STAT_BYTE, 8'h00},
      '{rcesc_pkg::OP_FLUSH,  13'd0,    14'd0,    14'd0,     1'b0, 0, rcesc_pkg::STAT_BYTE, 8'h00},
      '{rcesc_pkg::OP_LOAD,   13'd255,  14'd0,    14'h3FFF,  1'b1, 0, rcesc_pkg::STAT_BYTE, 8'h00},
      '{rcesc_pkg::OP_ENCODE, SYM_MAX,  14'd0,    14'd0,     1'b1, 1,
        rcesc_pkg::STAT_ZERO_FREQ, 8'h00},
      '{rcesc_pkg::OP_ENCODE, 13'd6000, 14'd0,    14'd0,     1'b1, 1,
        rcesc_pkg::STAT_ZERO_FREQ, 8'h00},
      '{rcesc_pkg::OP_ENCODE, 13'd300,  14'd0,    14'd0,     1'b0, 0, rcesc_pkg::STAT_BYTE, 8'h00},
      '{rcesc_pkg::OP_ENCODE, 13'd253,  14'd0,    14'd0,     1'b0, 0, rcesc_pkg::STAT_BYTE, 8'h00},
      '{OP_NOP,               13'd0,    14'd0,    14'd0,     1'b1, 0, rcesc_pkg::STAT_BYTE, 8'h00},
      '{rcesc_pkg::OP_FLUSH,  13'd0,    14'd0,    14'd0,     1'b0, 0, rcesc_pkg::STAT_BYTE, 8'h00}
   };

   // ---------------------------------------------------------------------------------------
   // Main sequence. Reset is held at the start and never raised again.
   // ---------------------------------------------------------------------------------------
   initial begin : stimulus
      int  run_len;
      int  pick;
      bit  pressure_done;
      pressure_done = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r])
         send_word(directed_rows[r].op, directed_rows[r].sym, directed_rows[r].frq,
                   directed_rows[r].cml, directed_rows[r].typed, directed_rows[r].count,
                   directed_rows[r].status, directed_rows[r].data);
      wait_drained();

      // Random part: mostly well-formed runs of symbols over freshly loaded tables, each
      // usually closed by a flush, with ignored words and the odd wild table mixed in.
      load_random_table(1'b0);
      while (words_counted < TOTAL_WORDS) begin
         if ($urandom_range(0, 2) == 0) load_random_table($urandom_range(0, 9) == 0);
         run_len = $urandom_range(3, 20);
         repeat (run_len) begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
               send_word(OP_NOP, 13'($urandom), 14'($urandom), 14'($urandom));
            else if (pick == 1)
               send_word(rcesc_pkg::OP_LOAD, 13'($urandom_range(256, SYM_MAX)),
                         14'($urandom), 14'($urandom));
            else
               encode_random();
         end
         if ($urandom_range(0, 4) != 0)
            send_word(rcesc_pkg::OP_FLUSH, 13'($urandom), 14'($urandom), 14'($urandom));

         // Once, part way through, the receiver holds off for a long time while words keep
         // coming back to back, so that the block fills up and stalls its request side.
         if (!pressure_done && words_counted > TOTAL_WORDS / 2) begin
            pressure_done = 1'b1;
            wait_drained();
            hold_pending = 1'b1;
            gaps_off     = 1'b1;
            repeat (40) begin
               if ($urandom_range(0, 1) != 0)
                  send_word(rcesc_pkg::OP_FLUSH, 13'($urandom), 14'($urandom),
                            14'($urandom));
               else
                  encode_random();
            end
            gaps_off = 1'b0;
         end

         if ($urandom_range(0, 5) == 0) wait_drained();
      end

      wait_drained();
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // Overall limit, far beyond the slowest correct run.
   initial begin : run_limit
      #2_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/core/rcesc_pkg.sv
rtl/core/range_coder_with_escape_symbols_top.sv
tb/sv/tb_range_coder_with_escape_symbols_top.sv
